[rtl/core/mlpsig_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlpsig_pkg
// Shared types, word layouts and helper functions of the sigmoid MLP block.
// ----------------------------------------------------------------------------
package mlpsig_pkg;

    // Input word: a weight write or one sample element.
    typedef struct packed {
        logic               mode;
        logic [1:0]         layer_sel;
        logic [3:0]         src_index;
        logic [3:0]         dst_index;
        logic signed [15:0] weight_value;
        logic signed [15:0] sample_value;
        logic               sample_last;
    } t_in_item;

    // Output word: one activation of the final layer.
    typedef struct packed {
        logic [12:0] activation;
        logic [3:0]  out_index;
        logic        out_last;
    } t_out_item;

    // Mode codes of an input word.
    localparam logic MODE_WEIGHT = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
    localparam logic [2:0] REG_SIZE_FIRST  = 3'd1;
    localparam logic [2:0] REG_SIZE_LAST   = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_weight;
        logic wr_sample;
        logic cnt_clear;
        logic mac_issue;
        logic mac_first;
        logic scale;
        logic dst_write;
        logic sel_b;
        logic out_load;
        logic out_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_stall;
    } t_sts;

    // Sigmoid at steps of 0.5, unsigned Q0.12.
    function automatic logic [12:0] sig_lut(input logic [4:0] idx);
        logic [12:0] v;
        unique case (idx)
            5'd0:    v = 13'd2048;
            5'd1:    v = 13'd2550;
            5'd2:    v = 13'd2994;
            5'd3:    v = 13'd3349;
            5'd4:    v = 13'd3608;
            5'd5:    v = 13'd3785;
            5'd6:    v = 13'd3902;
            5'd7:    v = 13'd3976;
            5'd8:    v = 13'd4022;
            5'd9:    v = 13'd4051;
            5'd10:   v = 13'd4069;
            5'd11:   v = 13'd4079;
            5'd12:   v = 13'd4086;
            5'd13:   v = 13'd4090;
            5'd14:   v = 13'd4092;
            5'd15:   v = 13'd4094;
            default: v = 13'd4095;
        endcase
        return v;
    endfunction

    // Clamp a size register into 1..cap.
    function automatic logic [4:0] clamp_size(input logic [4:0] v, input int cap);
        logic [4:0] r;
        if (v == 5'd0) begin
            r = 5'd1;
        end else if (int'(v) > cap) begin
            r = 5'(cap);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Clamp the layer count into 1..cap.
    function automatic logic [2:0] clamp_layers(input logic [2:0] v, input int cap);
        logic [2:0] r;
        if (v == 3'd0) begin
            r = 3'd1;
        end else if (int'(v) > cap) begin
            r = 3'(cap);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/mlpsig_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlpsig_stream_if
// Valid/ready channel carrying one word of payload type T.
// ----------------------------------------------------------------------------
interface mlpsig_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/mlp_sigmoid_forward_pass_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlp_sigmoid_forward_pass_top
// Bias-free fully connected network with a table sigmoid, run on demand.
// ----------------------------------------------------------------------------
// Channel   Dir  Word                       Handshake
// i_in      in   weight write / sample      valid & ready
// o_out     out  final activation + index   valid & ready
// i_cfg_*   in   register write             i_cfg_wr_en
//
// A weight or sample word is stored as it is accepted. The word marked last runs the
// pass: each layer takes its neurons in turn through MAC over sources, drain, scale and
// sigmoid on the single MAC unit, then the outputs leave one per cycle, unless stalled,
// through the output register. Input ready is low for the whole pass; output stalls
// hold the sequencer. Reset clears control state only; the weight memory is not reset.
// ----------------------------------------------------------------------------
module mlp_sigmoid_forward_pass_top #(
    parameter int MAX_LAYERS  = 4,
    parameter int MAX_NEURONS = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [4:0] i_cfg_data,
    mlpsig_stream_if.sink   i_in,
    mlpsig_stream_if.source o_out
);
    import mlpsig_pkg::*;

    localparam int NCAP = (MAX_NEURONS < 16) ? MAX_NEURONS : 16;
    localparam int LCAP = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
    localparam int LW   = (LCAP > 1) ? $clog2(LCAP) : 1;
    localparam int NIW  = $clog2(NCAP);

    t_cmd           w_cmd;
    t_sts           w_sts;
    t_in_item       w_item;
    logic [LW-1:0]  w_lay;
    logic [NIW-1:0] w_j;
    logic [NIW-1:0] w_k;
    logic           w_ready;

    assign w_item     = i_in.data;
    assign i_in.ready = w_ready;

    // Sequencer.
    mlpsig_ctrl #(
        .MAX_LAYERS (MAX_LAYERS),
        .MAX_NEURONS(MAX_NEURONS),
        .LW         (LW),
        .NIW        (NIW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in.valid),
        .i_in_mode  (w_item.mode),
        .i_in_last  (w_item.sample_last),
        .o_in_ready (w_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_lay      (w_lay),
        .o_j        (w_j),
        .o_k        (w_k)
    );

    // Datapath.
    mlpsig_dp #(
        .MAX_LAYERS (MAX_LAYERS),
        .MAX_NEURONS(MAX_NEURONS),
        .WEIGHT_BITS(WEIGHT_BITS),
        .LW         (LW),
        .NIW        (NIW)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (w_item),
        .i_cmd  (w_cmd),
        .i_lay  (w_lay),
        .i_j    (w_j),
        .i_k    (w_k),
        .o_sts  (w_sts),
        .o_out  (o_out)
    );

    // A word ending the sample closes the input for the pass.
    a_pass_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_ready && w_item.mode && w_item.sample_last) |=> !w_ready)
        else $error("input still open after pass start");

    // An output load never overwrites a word that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(o_out.valid && !o_out.ready))
        else $error("output word overwritten");

    // The MAC only runs while input is closed.
    a_mac_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mac_issue |-> !w_ready)
        else $error("MAC issued while accepting input");

endmodule
`default_nettype wire

[rtl/core/mlpsig_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlpsig_ctrl
// Configuration registers and the state machine sequencing a forward pass.
// ----------------------------------------------------------------------------
module mlpsig_ctrl #(
    parameter int MAX_LAYERS  = 4,
    parameter int MAX_NEURONS = 16,
    parameter int LW  = 2,
    parameter int NIW = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [2:0]       i_cfg_index,
    input  wire logic [4:0]       i_cfg_data,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_mode,
    input  wire logic             i_in_last,
    output logic                  o_in_ready,
    input  wire mlpsig_pkg::t_sts i_sts,
    output mlpsig_pkg::t_cmd      o_cmd,
    output logic [LW-1:0]         o_lay,
    output logic [NIW-1:0]        o_j,
    output logic [NIW-1:0]        o_k
);
    import mlpsig_pkg::*;

    localparam int NCAP = (MAX_NEURONS < 16) ? MAX_NEURONS : 16;
    localparam int LCAP = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
    localparam int NCW  = $clog2(NCAP + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MAC, ST_DRAIN_A, ST_DRAIN_B, ST_SCALE, ST_SIG, ST_OUT
    } t_state;

    t_state         r_state;
    logic [2:0]     r_cfg_layers;
    logic [4:0]     r_cfg_size [6];
    logic [LW-1:0]  r_l;
    logic [NIW-1:0] r_j;
    logic [NIW-1:0] r_k;
    logic [NCW-1:0] r_nsrc;
    logic [NCW-1:0] r_ndst;
    logic [2:0]     r_layers;

    logic           w_acc;
    logic           w_j_end;
    logic           w_k_end;
    logic           w_l_end;
    logic [2:0]     w_next_size;

    assign w_acc       = i_in_valid && o_in_ready;
    assign w_j_end     = NCW'(r_j) == (r_nsrc - NCW'(1));
    assign w_k_end     = NCW'(r_k) == (r_ndst - NCW'(1));
    assign w_l_end     = 3'(r_l) == (r_layers - 3'd1);
    // Size register of the layer that follows the current one.
    assign w_next_size = 3'(r_l) + 3'd3;

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_lay      = r_l;
    assign o_j        = r_j;
    assign o_k        = r_k;

    // Command decode per state.
    always_comb begin
        o_cmd           = '0;
        o_cmd.sel_b     = r_l[0];
        o_cmd.mac_first = (r_j == '0);
        o_cmd.out_last  = w_k_end;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.wr_weight = w_acc && (i_in_mode == MODE_WEIGHT);
                o_cmd.wr_sample = w_acc && (i_in_mode == MODE_SAMPLE);
                o_cmd.cnt_clear = w_acc && (i_in_mode == MODE_SAMPLE) && i_in_last;
            end
            ST_MAC:   o_cmd.mac_issue = 1'b1;
            ST_SCALE: o_cmd.scale = 1'b1;
            ST_SIG:   o_cmd.dst_write = 1'b1;
            ST_OUT: begin
                o_cmd.sel_b    = r_layers[0];
                o_cmd.out_load = !i_sts.out_stall;
            end
            default: o_cmd = '0;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_layers <= 3'd1;
            for (int i = 0; i < 6; i++) begin
                r_cfg_size[i] <= 5'd16;
            end
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == REG_LAYER_COUNT) begin
                r_cfg_layers <= i_cfg_data[2:0];
            end else if (i_cfg_index <= REG_SIZE_LAST) begin
                r_cfg_size[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    // Pass sequencer: MAC over sources, drain, scale, sigmoid, then output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_l      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_nsrc   <= NCW'(1);
            r_ndst   <= NCW'(1);
            r_layers <= 3'd1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc && (i_in_mode == MODE_SAMPLE) && i_in_last) begin
                        r_state  <= ST_MAC;
                        r_l      <= '0;
                        r_j      <= '0;
                        r_k      <= '0;
                        r_nsrc   <= NCW'(clamp_size(r_cfg_size[REG_SIZE_FIRST], NCAP));
                        r_ndst   <= NCW'(clamp_size(r_cfg_size[3'd2], NCAP));
                        r_layers <= clamp_layers(r_cfg_layers, LCAP);
                    end
                end
                ST_MAC: begin
                    if (w_j_end) begin
                        r_j     <= '0;
                        r_state <= ST_DRAIN_A;
                    end else begin
                        r_j <= r_j + NIW'(1);
                    end
                end
                ST_DRAIN_A: r_state <= ST_DRAIN_B;
                ST_DRAIN_B: r_state <= ST_SCALE;
                ST_SCALE:   r_state <= ST_SIG;
                ST_SIG: begin
                    if (w_k_end) begin
                        r_k <= '0;
                        if (w_l_end) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_l     <= r_l + LW'(1);
                            r_nsrc  <= r_ndst;
                            r_ndst  <= NCW'(clamp_size(r_cfg_size[w_next_size], NCAP));
                            r_state <= ST_MAC;
                        end
                    end else begin
                        r_k     <= r_k + NIW'(1);
                        r_state <= ST_MAC;
                    end
                end
                ST_OUT: begin
                    if (!i_sts.out_stall) begin
                        if (w_k_end) begin
                            r_k     <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_k <= r_k + NIW'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/core/mlpsig_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlpsig_dp
// Weight memory, activation buffers, MAC pipeline, sigmoid and output register.
// ----------------------------------------------------------------------------
module mlpsig_dp #(
    parameter int MAX_LAYERS  = 4,
    parameter int MAX_NEURONS = 16,
    parameter int WEIGHT_BITS = 16,
    parameter int LW  = 2,
    parameter int NIW = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire mlpsig_pkg::t_in_item i_item,
    input  wire mlpsig_pkg::t_cmd     i_cmd,
    input  wire logic [LW-1:0]        i_lay,
    input  wire logic [NIW-1:0]       i_j,
    input  wire logic [NIW-1:0]       i_k,
    output mlpsig_pkg::t_sts          o_sts,
    mlpsig_stream_if.source           o_out
);
    import mlpsig_pkg::*;

    localparam int NCAP  = (MAX_NEURONS < 16) ? MAX_NEURONS : 16;
    localparam int NCW   = $clog2(NCAP + 1);
    localparam int DEPTH = MAX_LAYERS * MAX_NEURONS * MAX_NEURONS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = 16 + WEIGHT_BITS;
    localparam int ACC_W = PW + $clog2(NCAP) + 1;

    localparam logic signed [32:0] WMAX = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] WMIN = -WMAX - 33'sd1;

    logic signed [WEIGHT_BITS-1:0] r_wmem [DEPTH];
    logic signed [15:0]            r_buf_a [NCAP];
    logic signed [15:0]            r_buf_b [NCAP];
    logic [NCW-1:0]                r_cnt;

    logic signed [WEIGHT_BITS-1:0] r_w;
    logic signed [15:0]            r_a;
    logic                          r_v1;
    logic                          r_f1;
    logic signed [PW-1:0]          r_prod;
    logic                          r_v2;
    logic                          r_f2;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [15:0]            r_x;

    logic                          r_ov;
    t_out_item                     r_out;

    logic signed [32:0]            w_w33;
    logic signed [WEIGHT_BITS-1:0] w_wsat;
    logic [AW-1:0]                 w_waddr;
    logic [AW-1:0]                 w_raddr;
    logic                          w_win;
    logic signed [ACC_W-1:0]       w_t;
    logic signed [ACC_W-1:0]       w_q;
    logic signed [15:0]            w_xsat;
    logic [16:0]                   w_abs;
    logic [5:0]                    w_seg;
    logic [12:0]                   w_base;
    logic [12:0]                   w_diff;
    logic [23:0]                   w_interp;
    logic [12:0]                   w_ypos;
    logic [12:0]                   w_y;
    logic signed [15:0]            w_src;

    // Weight write: saturate to the stored width and check the address.
    always_comb begin
        w_w33 = 33'(i_item.weight_value);
        if (w_w33 > WMAX) begin
            w_wsat = WEIGHT_BITS'(WMAX);
        end else if (w_w33 < WMIN) begin
            w_wsat = WEIGHT_BITS'(WMIN);
        end else begin
            w_wsat = WEIGHT_BITS'(w_w33);
        end
        w_win   = (int'(i_item.layer_sel) < MAX_LAYERS)
               && (int'(i_item.src_index) < MAX_NEURONS)
               && (int'(i_item.dst_index) < MAX_NEURONS);
        w_waddr = AW'(int'(i_item.layer_sel) * MAX_NEURONS * MAX_NEURONS
                + int'(i_item.src_index) * MAX_NEURONS + int'(i_item.dst_index));
        w_raddr = AW'(int'(i_lay) * MAX_NEURONS * MAX_NEURONS
                + int'(i_j) * MAX_NEURONS + int'(i_k));
    end

    // Weight memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_weight && w_win) begin
            r_wmem[w_waddr] <= w_wsat;
        end
        r_w <= r_wmem[w_raddr];
    end

    // Sample count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clear) begin
            r_cnt <= '0;
        end else if (i_cmd.wr_sample && (int'(r_cnt) < NCAP)) begin
            r_cnt <= r_cnt + NCW'(1);
        end
    end

    // Activation buffers: samples fill buffer A, layers ping-pong A and B.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_sample && (int'(r_cnt) < NCAP)) begin
            r_buf_a[r_cnt[NIW-1:0]] <= i_item.sample_value;
        end
        if (i_cmd.dst_write) begin
            if (i_cmd.sel_b) begin
                r_buf_a[i_k] <= 16'(w_y);
            end else begin
                r_buf_b[i_k] <= 16'(w_y);
            end
        end
    end

    // MAC pipeline: operand read, product, accumulate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
        end
        r_a    <= i_cmd.sel_b ? r_buf_b[i_j] : r_buf_a[i_j];
        r_f1   <= i_cmd.mac_first;
        r_prod <= PW'(r_a) * PW'(r_w);
        r_f2   <= r_f1;
        if (r_v2) begin
            r_acc <= r_f2 ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    // Round half up, divide by 4096 and saturate to Q3.12.
    always_comb begin
        w_t = r_acc + ACC_W'(2048);
        w_q = w_t >>> 12;
        if (w_q > ACC_W'(32767)) begin
            w_xsat = 16'sh7fff;
        end else if (w_q < -ACC_W'(32768)) begin
            w_xsat = -16'sh8000;
        end else begin
            w_xsat = 16'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_x <= w_xsat;
        end
    end

    // Sigmoid: table of half steps with linear interpolation, mirrored for x < 0.
    always_comb begin
        w_abs    = r_x[15] ? 17'(-17'(r_x)) : 17'(r_x);
        w_seg    = w_abs[16:11];
        w_base   = sig_lut(w_seg[4:0]);
        w_diff   = sig_lut(w_seg[4:0] + 5'd1) - w_base;
        w_interp = 24'(w_diff) * 24'(w_abs[10:0]) + 24'd1024;
        if (w_seg >= 6'd16) begin
            w_ypos = sig_lut(5'd16);
        end else begin
            w_ypos = w_base + 13'(w_interp >> 11);
        end
        w_y = r_x[15] ? 13'd4096 - w_ypos : w_ypos;
    end

    // Output register.
    assign w_src          = i_cmd.sel_b ? r_buf_b[i_k] : r_buf_a[i_k];
    assign o_sts.out_stall = r_ov && !o_out.ready;
    assign o_out.valid    = r_ov;
    assign o_out.data     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out.activation <= w_src[12:0];
            r_out.out_index  <= 4'(i_k);
            r_out.out_last   <= i_cmd.out_last;
        end
    end

endmodule
`default_nettype wire

[test/tb_mlp_sigmoid_forward_pass_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_mlp_sigmoid_forward_pass_top
// Self-checking bench for the sigmoid MLP forward pass. A behavioral network
// model predicts the final activations of every pass; results are compared
// field by field in order. The weight store is filled first so that no
// unwritten entry is ever read. A directed table runs first, then random
// weight and sample traffic over several register settings.
// ----------------------------------------------------------------------------
module tb_mlp_sigmoid_forward_pass_top;
    import mlpsig_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int DRAIN_CYCLES = 60;

    // One stimulus word, optionally with a typed-in activation for the pass.
    typedef struct {
        t_in_item    word;
        bit          chk;
        logic [12:0] act;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [2:0] i_cfg_index;
    logic [4:0] i_cfg_data;

    mlpsig_stream_if #(.T(t_in_item))  in_if ();
    mlpsig_stream_if #(.T(t_out_item)) out_if ();

    mlp_sigmoid_forward_pass_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Network model state.
    int          net_weight[1024];
    int          net_act_a[16];
    int          net_act_b[16];
    int          net_count;
    logic [4:0]  net_reg[6];

    t_row        word_q[$];
    t_out_item   act_q[$];
    int          fails;
    int          cycles;
    int          send_idle_pct;
    int          recv_idle_pct;

    const int sig_lut_tb[17] = '{2048, 2550, 2994, 3349, 3608, 3785, 3902, 3976,
                                 4022, 4051, 4069, 4079, 4086, 4090, 4092, 4094,
                                 4095};

    function automatic int net_sigmoid(input int x);
        int a, seg, frac, y;
        a = (x < 0) ? -x : x;
        seg = a >> 11;
        frac = a & 2047;
        if (seg >= 16) begin
            y = sig_lut_tb[16];
        end else begin
            y = sig_lut_tb[seg] + (((sig_lut_tb[seg + 1] - sig_lut_tb[seg]) * frac + 1024) >> 11);
        end
        return (x < 0) ? 4096 - y : y;
    endfunction

    function automatic int net_scale(input longint acc);
        longint q;
        q = (acc + 2048) >>> 12;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    function automatic int net_size(input logic [4:0] v);
        if (v == 0) return 1;
        if (v > 16) return 16;
        return int'(v);
    endfunction

    function automatic void report_fail(input string what);
        if (fails < 10) $display("mismatch: %s", what);
        fails++;
    endfunction

    // Apply one accepted word to the model and queue the results of a pass.
    function automatic void net_predict(input t_row r);
        int layers, n_src, n_dst, l, j, k;
        longint acc;
        bit on_b;
        int v;
        t_out_item o;
        if (r.word.mode == MODE_WEIGHT) begin
            net_weight[{r.word.layer_sel, r.word.src_index, r.word.dst_index}] =
                int'(r.word.weight_value);
            return;
        end
        if (net_count < 16) begin
            net_act_a[net_count] = int'(r.word.sample_value);
            net_count++;
        end
        if (!r.word.sample_last) return;
        net_count = 0;
        layers = (net_reg[0] == 0) ? 1 : ((net_reg[0] > 4) ? 4 : int'(net_reg[0]));
        n_src = net_size(net_reg[1]);
        n_dst = n_src;
        on_b = 1'b0;
        for (l = 0; l < layers; l++) begin
            n_dst = net_size(net_reg[l + 2]);
            for (k = 0; k < n_dst; k++) begin
                acc = 0;
                for (j = 0; j < n_src; j++) begin
                    acc += longint'(on_b ? net_act_b[j] : net_act_a[j]) *
                           longint'(net_weight[l * 256 + j * 16 + k]);
                end
                v = net_sigmoid(net_scale(acc));
                if (on_b) net_act_a[k] = v;
                else net_act_b[k] = v;
            end
            on_b = !on_b;
            n_src = n_dst;
        end
        for (k = 0; k < n_dst; k++) begin
            o.activation = 13'(on_b ? net_act_b[k] : net_act_a[k]);
            o.out_index  = 4'(k);
            o.out_last   = (k + 1 == n_dst);
            if (r.chk && o.activation !== r.act)
                report_fail($sformatf("table neuron %0d expected %0d model %0d",
                                      k, r.act, o.activation));
            act_q.push_back(o);
        end
    endfunction

    // Clock and run limit.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Word sender: hold a word until it is taken, idle at random otherwise.
    // An accepted word leaves the queue first, so the next one is always at the head.
    always @(posedge i_clk) begin
        t_row r;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                r = word_q.pop_front();
                net_predict(r);
            end
            if (in_if.valid && !in_if.ready) begin
                in_if.valid <= 1'b1;
            end else if (word_q.size() > 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                in_if.valid <= 1'b1;
                in_if.data  <= word_q[0].word;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver and checker.
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (act_q.size() == 0) begin
                    report_fail("result word with nothing expected");
                end else begin
                    e = act_q.pop_front();
                    if (out_if.data !== e)
                        report_fail($sformatf("act %0d/%0d idx %0d/%0d last %0d/%0d",
                            e.activation, out_if.data.activation, e.out_index,
                            out_if.data.out_index, e.out_last, out_if.data.out_last));
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_in_item rand_word();
        t_in_item w;
        w = t_in_item'(44'({$urandom, $urandom}));
        if ($urandom_range(3) != 0) w.weight_value = 16'($signed($urandom_range(8191)) - 4096);
        if ($urandom_range(3) != 0) w.sample_value = 16'($signed($urandom_range(16383)) - 8192);
        return w;
    endfunction

    task automatic push_word(input t_in_item w);
        t_row r;
        r.word = w;
        r.chk = 1'b0;
        r.act = '0;
        word_q.push_back(r);
    endtask

    task automatic wait_idle();
        wait (word_q.size() == 0);
        @(posedge i_clk);
        while (in_if.valid || act_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [4:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == REG_LAYER_COUNT) net_reg[0] = {2'b00, val[2:0]};
        else net_reg[idx] = val;
    endtask

    // Main sequence.
    initial begin
        t_row       table_rows[$];
        t_row       r;
        t_in_item   w;
        int         ph, n, len, kind, i;
        logic [4:0] size_sel;

        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        fails = 0;
        cycles = 0;
        send_idle_pct = 23;
        recv_idle_pct = 82;
        net_count = 0;
        net_reg[0] = 5'd1;
        for (i = 1; i < 6; i++) net_reg[i] = 5'd16;
        foreach (net_weight[i]) net_weight[i] = 0;
        foreach (net_act_a[i]) net_act_a[i] = 0;
        foreach (net_act_b[i]) net_act_b[i] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Clear the whole weight store so every later read is defined.
        for (i = 0; i < 1024; i++) begin
            w = rand_word();
            w.mode = MODE_WEIGHT;
            {w.layer_sel, w.src_index, w.dst_index} = 10'(i);
            w.weight_value = '0;
            push_word(w);
        end

        // Directed table. With zero weights every neuron sits at sigmoid(0).
        for (i = 0; i < 16; i++) begin
            r.word = rand_word();
            r.word.mode = MODE_SAMPLE;
            r.word.sample_value = (i == 0) ? 16'sh7FFF : (i == 1) ? 16'sh8000 : 16'(i * 977);
            r.word.sample_last = (i == 15);
            r.chk = (i == 15);
            r.act = 13'd2048;
            table_rows.push_back(r);
        end
        // Weight extremes, top layer and edge indexes.
        r.chk = 1'b0;
        r.word = rand_word(); r.word.mode = MODE_WEIGHT;
        {r.word.layer_sel, r.word.src_index, r.word.dst_index} = 10'h000;
        r.word.weight_value = 16'sh7FFF; table_rows.push_back(r);
        r.word = rand_word(); r.word.mode = MODE_WEIGHT;
        {r.word.layer_sel, r.word.src_index, r.word.dst_index} = 10'h01F;
        r.word.weight_value = 16'sh8000; table_rows.push_back(r);
        r.word = rand_word(); r.word.mode = MODE_WEIGHT;
        {r.word.layer_sel, r.word.src_index, r.word.dst_index} = 10'h3FF;
        r.word.weight_value = 16'sh8000; table_rows.push_back(r);
        // Short sample: a single element with the last marker.
        r.word = rand_word(); r.word.mode = MODE_SAMPLE;
        r.word.sample_value = 16'sh7FFF; r.word.sample_last = 1'b1;
        table_rows.push_back(r);
        r.word.sample_value = 16'sh8000; table_rows.push_back(r);
        foreach (table_rows[i]) word_q.push_back(table_rows[i]);
        wait_idle();

        // Random phases over several register settings.
        for (ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin send_idle_pct = 82; recv_idle_pct = 23; end
            if (ph == 4) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            if (ph == 1) begin
                // Zero registers clamp to one layer of one neuron.
                cfg_write(REG_LAYER_COUNT, 5'd0);
                for (i = REG_SIZE_FIRST; i <= REG_SIZE_LAST; i++) cfg_write(3'(i), 5'd0);
            end else if (ph == 2) begin
                // Over-range registers clamp to the maximum network.
                cfg_write(REG_LAYER_COUNT, 5'd7);
                for (i = REG_SIZE_FIRST; i <= REG_SIZE_LAST; i++) cfg_write(3'(i), 5'd31);
            end else if (ph > 2) begin
                cfg_write(REG_LAYER_COUNT, 5'($urandom_range(4, 1)));
                for (i = REG_SIZE_FIRST; i <= REG_SIZE_LAST; i++)
                    cfg_write(3'(i), 5'($urandom_range(6, 1)));
            end
            n = 0;
            while (n < ((ph == 2) ? 40 : 70)) begin
                kind = $urandom_range(99);
                if (kind < 30) begin
                    w = rand_word();
                    w.mode = MODE_WEIGHT;
                    push_word(w);
                    n++;
                end else begin
                    size_sel = 5'(net_size(net_reg[1]));
                    len = (kind < 92) ? int'(size_sel) : $urandom_range(20, 1);
                    for (i = 0; i < len; i++) begin
                        w = rand_word();
                        w.mode = MODE_SAMPLE;
                        w.sample_last = (i == len - 1);
                        push_word(w);
                    end
                    n += len;
                end
            end
            wait_idle();
        end

        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
